// File: rtl/core/nls_pkg.sv
// shared types, constants and codes of the numbered line store
package nls_pkg;

    localparam int STORE_BYTES     = 4096;
    localparam int LINE_BYTES      = 128;
    localparam int RECORD_OVERHEAD = 3;

    localparam int SA_W  = $clog2(STORE_BYTES);
    localparam int SP_W  = SA_W + 1;
    localparam int LB_AW = $clog2(LINE_BYTES);
    localparam int LB_CW = $clog2(LINE_BYTES + 1);

    localparam logic [1:0] OP_ENTER = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_BUFFERED = 3'd1;
    localparam logic [2:0] ST_NOMEM    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_TOOLONG  = 3'd4;

    localparam logic REG_PROGRAM_START = 1'b0;
    localparam logic REG_STORE_LIMIT   = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] line_number;
        logic [7:0]  text_byte;
        logic [11:0] byte_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] line_address;
        logic [15:0] found_number;
        logic [7:0]  read_data;
    } t_result;

    typedef enum logic [2:0] {
        CMD_TEXT,
        CMD_COMMIT,
        CMD_FIND,
        CMD_READ,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] line_number;
        logic [7:0]  text_byte;
        logic [11:0] byte_address;
    } t_cmd_item;

    typedef struct packed {
        logic      valid;
        t_cmd_item item;
    } t_queue_head;

endpackage

// File: rtl/core/nls_front.sv
// front end: transaction intake, command classification and a two entry queue
module nls_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  nls_pkg::t_in_item i_item,
    output nls_pkg::t_queue_head o_head,
    input  logic              i_pop
);
    import nls_pkg::*;

    t_cmd_item  r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd_item  w_new;
    logic       w_push;

    always_comb begin
        w_new.line_number  = i_item.line_number;
        w_new.text_byte    = i_item.text_byte;
        w_new.byte_address = i_item.byte_address;
        unique case (i_item.op)
            OP_ENTER: w_new.cmd = (i_item.text_byte != 8'd0) ? CMD_TEXT : CMD_COMMIT;
            OP_FIND:  w_new.cmd = CMD_FIND;
            OP_READ:  w_new.cmd = CMD_READ;
            default:  w_new.cmd = CMD_NOP;
        endcase
    end

    assign busy        = (r_cnt == 2'd2);
    assign w_push      = start && !busy;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: rtl/core/nls_back.sv
// back end: store memory, line buffer and the search, delete and insert sequencer
module nls_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nls_pkg::t_queue_head i_head,
    output logic                 o_pop,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    output logic                 o_result_strobe,
    output nls_pkg::t_result     o_result
);
    import nls_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_SK_CHK, S_SK_LO, S_SK_HI, S_SKIP_CHK, S_SKIP_USE,
        S_DS_CHK, S_DS_USE, S_DC_CHK, S_DC_WR, S_INS, S_SH_CHK, S_SH_WR,
        S_WR_LO, S_WR_HI, S_LB_CHK, S_LB_WR
    } t_state;

    logic [7:0]      r_store [STORE_BYTES];
    logic [7:0]      r_lbuf  [LINE_BYTES];
    logic [7:0]      r_rd;
    logic [7:0]      r_lb_rd;

    t_state          r_state, n_state;
    t_cmd_item       r_it, n_it;
    logic [SP_W-1:0] r_start, n_start;
    logic [SP_W-1:0] r_limit, n_limit;
    logic [SP_W-1:0] r_end, n_end;
    logic [SP_W-1:0] r_p, n_p;
    logic [SP_W-1:0] r_d, n_d;
    logic [SP_W-1:0] r_cur, n_cur;
    logic [7:0]      r_lo, n_lo;
    logic [LB_CW-1:0] r_cnt, n_cnt;
    logic [LB_CW-1:0] r_i, n_i;
    logic            r_ovf, n_ovf;
    logic            r_res_v, n_res_v;
    t_result         r_res, n_res;

    logic            w_we;
    logic [SA_W-1:0] w_addr;
    logic [7:0]      w_wdata;
    logic            w_lb_we;
    logic [LB_AW-1:0] w_lb_addr;
    logic [15:0]     w_word;
    logic [SP_W-1:0] w_size;
    logic [SP_W-1:0] w_lim;
    logic [SP_W-1:0] w_pos;

    assign w_word = {r_rd, r_lo};
    assign w_size = SP_W'(r_cnt) + SP_W'(RECORD_OVERHEAD);
    assign w_lim  = (r_limit < SP_W'(STORE_BYTES)) ? r_limit : SP_W'(STORE_BYTES);
    assign w_pos  = r_cur + SP_W'(2) + SP_W'(r_i);
    assign o_pop  = i_head.valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_addr] <= w_wdata;
        end
        r_rd <= r_store[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_lb_we) begin
            r_lbuf[w_lb_addr] <= i_head.item.text_byte;
        end
        r_lb_rd <= r_lbuf[w_lb_addr];
    end

    always_comb begin
        n_state = r_state;
        n_it    = r_it;
        n_start = r_start;
        n_limit = r_limit;
        n_end   = r_end;
        n_p     = r_p;
        n_d     = r_d;
        n_cur   = r_cur;
        n_lo    = r_lo;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_ovf   = r_ovf;
        n_res_v = 1'b0;
        n_res   = '0;
        w_we    = 1'b0;
        w_addr  = r_p[SA_W-1:0];
        w_wdata = 8'd0;
        w_lb_we = 1'b0;
        w_lb_addr = r_i[LB_AW-1:0];

        if (i_cfg_valid) begin
            if (i_cfg_index == REG_PROGRAM_START) begin
                n_start = {1'b0, i_cfg_data[SA_W-1:0]};
                n_end   = {1'b0, i_cfg_data[SA_W-1:0]};
            end else begin
                n_limit = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_it = i_head.item;
                    n_p  = r_start;
                    unique case (i_head.item.cmd)
                        CMD_TEXT: begin
                            n_it = i_head.item;
                            n_res_v = 1'b1;
                            n_res.status = ST_BUFFERED;
                            if (r_cnt < LB_CW'(LINE_BYTES)) begin
                                n_cnt = r_cnt + LB_CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        CMD_COMMIT: begin
                            if (r_ovf) begin
                                n_res_v = 1'b1;
                                n_res.status = ST_TOOLONG;
                                n_cnt = '0;
                                n_ovf = 1'b0;
                            end else begin
                                n_state = S_SK_CHK;
                            end
                        end
                        CMD_FIND: n_state = S_SK_CHK;
                        CMD_READ: n_state = S_RD;
                        default: begin
                            n_res_v = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_res_v = 1'b1;
                n_res.read_data = r_rd;
                n_state = S_IDLE;
            end
            S_SK_CHK: begin
                if (r_p >= r_end) begin
                    n_cur = r_end;
                    if (r_it.cmd == CMD_FIND) begin
                        n_res_v = 1'b1;
                        n_res.status = ST_NOTFOUND;
                        n_res.line_address = r_end[SA_W-1:0];
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_state = S_SK_LO;
                end
            end
            S_SK_LO: begin
                w_addr  = r_p[SA_W-1:0] + SA_W'(1);
                n_lo    = r_rd;
                n_state = S_SK_HI;
            end
            S_SK_HI: begin
                if (w_word >= r_it.line_number) begin
                    n_cur = r_p;
                    if (r_it.cmd == CMD_FIND) begin
                        n_res_v = 1'b1;
                        n_res.line_address = r_p[SA_W-1:0];
                        n_res.found_number = w_word;
                        n_state = S_IDLE;
                    end else if (w_word == r_it.line_number) begin
                        n_d = r_p;
                        n_p = r_p + SP_W'(2);
                        n_state = S_DS_CHK;
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_p = r_p + SP_W'(2);
                    n_state = S_SKIP_CHK;
                end
            end
            S_SKIP_CHK: n_state = (r_p < r_end) ? S_SKIP_USE : S_SK_CHK;
            S_SKIP_USE: begin
                n_p = r_p + SP_W'(1);
                n_state = (r_rd == 8'd0) ? S_SK_CHK : S_SKIP_CHK;
            end
            S_DS_CHK: n_state = (r_p < r_end) ? S_DS_USE : S_DC_CHK;
            S_DS_USE: begin
                n_p = r_p + SP_W'(1);
                n_state = (r_rd == 8'd0) ? S_DC_CHK : S_DS_CHK;
            end
            S_DC_CHK: begin
                if (r_p < r_end) begin
                    n_state = S_DC_WR;
                end else begin
                    n_end = r_d;
                    n_state = S_INS;
                end
            end
            S_DC_WR: begin
                w_we    = 1'b1;
                w_addr  = r_d[SA_W-1:0];
                w_wdata = r_rd;
                n_d = r_d + SP_W'(1);
                n_p = r_p + SP_W'(1);
                n_state = S_DC_CHK;
            end
            S_INS: begin
                if (r_cnt == '0) begin
                    n_res_v = 1'b1;
                    n_res.line_address = r_cur[SA_W-1:0];
                    n_ovf = 1'b0;
                    n_state = S_IDLE;
                end else if (r_end + w_size >= w_lim) begin
                    n_res_v = 1'b1;
                    n_res.status = ST_NOMEM;
                    n_res.line_address = r_cur[SA_W-1:0];
                    n_cnt = '0;
                    n_ovf = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_p = r_end;
                    n_d = r_end + w_size;
                    n_end = r_end + w_size;
                    n_state = S_SH_CHK;
                end
            end
            S_SH_CHK: begin
                if (r_p > r_cur) begin
                    w_addr = r_p[SA_W-1:0] - SA_W'(1);
                    n_p = r_p - SP_W'(1);
                    n_d = r_d - SP_W'(1);
                    n_state = S_SH_WR;
                end else begin
                    n_state = S_WR_LO;
                end
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_addr  = r_d[SA_W-1:0];
                w_wdata = r_rd;
                n_state = S_SH_CHK;
            end
            S_WR_LO: begin
                w_we    = 1'b1;
                w_addr  = r_cur[SA_W-1:0];
                w_wdata = r_it.line_number[7:0];
                n_state = S_WR_HI;
            end
            S_WR_HI: begin
                w_we    = 1'b1;
                w_addr  = r_cur[SA_W-1:0] + SA_W'(1);
                w_wdata = r_it.line_number[15:8];
                n_i = '0;
                n_state = S_LB_CHK;
            end
            S_LB_CHK: begin
                if (r_i < r_cnt) begin
                    n_state = S_LB_WR;
                end else begin
                    w_we    = 1'b1;
                    w_addr  = w_pos[SA_W-1:0];
                    n_res_v = 1'b1;
                    n_res.line_address = r_cur[SA_W-1:0];
                    n_cnt = '0;
                    n_ovf = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_LB_WR: begin
                w_we    = 1'b1;
                w_addr  = w_pos[SA_W-1:0];
                w_wdata = r_lb_rd;
                n_i = r_i + LB_CW'(1);
                n_state = S_LB_CHK;
            end
            default: n_state = S_IDLE;
        endcase

        if (r_state == S_IDLE && i_head.valid && i_head.item.cmd == CMD_TEXT
                && r_cnt < LB_CW'(LINE_BYTES)) begin
            w_lb_we   = 1'b1;
            w_lb_addr = r_cnt[LB_AW-1:0];
        end
        if (r_state == S_IDLE && i_head.valid && i_head.item.cmd == CMD_READ) begin
            w_addr = i_head.item.byte_address;
        end
    end

    // line buffer write takes the byte straight from the queue head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_limit <= SP_W'(STORE_BYTES);
            r_end   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_res_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_limit <= n_limit;
            r_end   <= n_end;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_res_v <= n_res_v;
        end
        r_it  <= n_it;
        r_p   <= n_p;
        r_d   <= n_d;
        r_cur <= n_cur;
        r_lo  <= n_lo;
        r_i   <= n_i;
        r_res <= n_res;
    end

    assign o_result_strobe = r_res_v;
    assign o_result        = r_res;

endmodule

// File: rtl/core/numbered_line_store_unit.sv
// top level of the numbered line store: front queue, back sequencer and checks
// A command is taken when start is high and busy is low; each command gives exactly one
// result, shown for one cycle with o_result_strobe, and the receiver cannot hold it off.
// Text bytes and unused codes are answered from the idle state, reads from a read state.
// Find walks the records from program_start. Entering a line searches, then may shift the
// store above the insertion point one byte at a time through the single store memory port.
// Up to two commands queue ahead of the sequencer. Writing program_start empties the store.
module numbered_line_store_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  nls_pkg::t_in_item i_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [12:0]       i_cfg_data,
    output logic              o_result_strobe,
    output nls_pkg::t_result  o_result
);
    import nls_pkg::*;

    t_queue_head w_head;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;

    nls_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    nls_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid) else $error("pop from empty queue");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> o_result.status <= ST_TOOLONG) else $error("bad status");
    a_buffered_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.status == ST_BUFFERED) |->
        (o_result.line_address == '0 && o_result.read_data == '0))
        else $error("buffered result carries data");
`endif

endmodule
